[hdl/dpp_pkg.sv]
package dpp_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned LIMIT_W   = 15;
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned TICK_W    = 10;
  localparam int unsigned BAND_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TICK_W-1:0] TIMEOUT_TICKS = 10'd650;

  localparam logic [LIMIT_W-1:0] ZONE_RESET  = 15'd2560;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd3072;
  localparam logic [LIMIT_W-1:0] BAND_RESET  = 15'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_GAIN_D       = 3'd2,
    REG_TARGET       = 3'd3,
    REG_INTEG_ZONE   = 3'd4,
    REG_OUTPUT_LIMIT = 3'd5,
    REG_SETTLE_BAND  = 3'd6,
    REG_SETTLE_TICKS = 3'd7
  } cfg_reg_t;

endpackage

[hdl/dpp_if.sv]
interface dpp_tick_if;
  logic                                valid;
  logic                                ready;
  logic                                start_req;
  logic signed [dpp_pkg::DATA_W-1:0]   position;

  modport source (output valid, start_req, position, input ready);
  modport sink   (input valid, start_req, position, output ready);
endinterface

interface dpp_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [dpp_pkg::DATA_W-1:0]   drive;
  logic signed [dpp_pkg::DATA_W-1:0]   error_now;
  logic                                settled;
  logic                                timed_out;

  modport source (output valid, drive, error_now, settled, timed_out, input ready);
  modport sink   (input valid, drive, error_now, settled, timed_out, output ready);
endinterface

[hdl/drive_position_pid.sv]
// Position PID loop with integral zone and settle detection. One control tick
// is taken per clock unless the pipeline is backed up; its result passes the
// registered stages error/state update, gain multiplies, and sum and clamp
// before it is offered. A stalled result side backs up the three-stage
// pipeline before the tick side stops. Loop state (integral, last error, band
// and tick counts) updates at the tick's transfer, so back-to-back ticks see
// each other's state. Configuration is taken through cfg_we/cfg_index/cfg_data
// and should only change while idle.
module drive_position_pid (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dpp_pkg::DATA_W-1:0]           cfg_data,
  dpp_tick_if.sink                             tick,
  dpp_result_if.source                         result
);

  // configuration
  logic [15:0]        gain_p, gain_i, gain_d;
  logic signed [15:0] target_position;
  logic [14:0]        integral_zone, output_limit, settle_band;
  logic [7:0]         settle_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      target_position <= '0;
      integral_zone   <= dpp_pkg::ZONE_RESET;
      output_limit    <= dpp_pkg::LIMIT_RESET;
      settle_band     <= dpp_pkg::BAND_RESET;
      settle_ticks    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpp_pkg::REG_GAIN_P:       gain_p          <= cfg_data;
        dpp_pkg::REG_GAIN_I:       gain_i          <= cfg_data;
        dpp_pkg::REG_GAIN_D:       gain_d          <= cfg_data;
        dpp_pkg::REG_TARGET:       target_position <= $signed(cfg_data);
        dpp_pkg::REG_INTEG_ZONE:   integral_zone   <= cfg_data[14:0];
        dpp_pkg::REG_OUTPUT_LIMIT: output_limit    <= cfg_data[14:0];
        dpp_pkg::REG_SETTLE_BAND:  settle_band     <= cfg_data[14:0];
        default:                   settle_ticks    <= cfg_data[7:0];
      endcase
    end
  end

  // pipeline flow control
  logic st1_valid, st2_valid, out_valid;
  logic out_free, st2_free, st1_free, tick_xfer;

  assign out_free  = !out_valid || result.ready;
  assign st2_free  = !st2_valid || out_free;
  assign st1_free  = !st1_valid || st2_free;
  assign tick.ready = st1_free;
  assign tick_xfer = tick.valid && tick.ready;

  // loop state
  logic signed [15:0] last_error;
  logic signed [23:0] error_sum;
  logic [7:0]         band_count;
  logic [9:0]         tick_count;

  logic signed [16:0] diff, deriv;
  logic signed [15:0] err;
  logic [16:0]        err_neg;
  logic [15:0]        mag;
  logic signed [23:0] sum_base, error_sum_next;
  logic signed [24:0] sum_add;
  logic [7:0]         band_base, band_count_next;
  logic [9:0]         tick_base, tick_count_next;
  logic               timed_next, settled_next;

  always_comb begin
    diff = {target_position[15], target_position} - {tick.position[15], tick.position};
    if (diff[16] != diff[15]) begin
      err = diff[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      err = diff[15:0];
    end
    deriv   = {err[15], err} - {last_error[15], last_error};
    err_neg = 17'd0 - {err[15], err};
    mag     = err[15] ? err_neg[15:0] : err;

    sum_base  = tick.start_req ? '0 : error_sum;
    band_base = tick.start_req ? '0 : band_count;
    tick_base = tick.start_req ? '0 : tick_count;

    sum_add = {sum_base[23], sum_base} + {{9{err[15]}}, err};
    if (mag >= {1'b0, integral_zone}) begin
      error_sum_next = '0;
    end else if (sum_add[24] != sum_add[23]) begin
      error_sum_next = sum_add[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      error_sum_next = sum_add[23:0];
    end

    tick_count_next = (tick_base == '1) ? tick_base : tick_base + 10'd1;
    if (mag < {1'b0, settle_band}) begin
      band_count_next = (band_base == '1) ? band_base : band_base + 8'd1;
    end else begin
      band_count_next = '0;
    end

    timed_next   = tick_count_next >= dpp_pkg::TIMEOUT_TICKS;
    settled_next = (band_count_next > settle_ticks) || timed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
      band_count <= '0;
      tick_count <= '0;
    end else if (tick_xfer) begin
      last_error <= err;
      error_sum  <= error_sum_next;
      band_count <= band_count_next;
      tick_count <= tick_count_next;
    end
  end

  // stage 1: error terms and flags
  logic signed [15:0] st1_err;
  logic signed [16:0] st1_deriv;
  logic signed [23:0] st1_sum;
  logic               st1_settled, st1_timed;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (st1_free) begin
      st1_valid <= tick.valid;
    end
    if (tick_xfer) begin
      st1_err     <= err;
      st1_deriv   <= deriv;
      st1_sum     <= error_sum_next;
      st1_settled <= settled_next;
      st1_timed   <= timed_next;
    end
  end

  // stage 2: gain products
  logic signed [32:0] prod_p, st2_prod_p;
  logic signed [40:0] prod_i, st2_prod_i;
  logic signed [33:0] prod_d, st2_prod_d;
  logic signed [15:0] st2_err;
  logic               st2_settled, st2_timed;

  assign prod_p = st1_err   * $signed({1'b0, gain_p});
  assign prod_i = st1_sum   * $signed({1'b0, gain_i});
  assign prod_d = st1_deriv * $signed({1'b0, gain_d});

  always_ff @(posedge clk) begin
    if (rst) begin
      st2_valid <= 1'b0;
    end else if (st2_free) begin
      st2_valid <= st1_valid;
    end
    if (st2_free && st1_valid) begin
      st2_prod_p  <= prod_p;
      st2_prod_i  <= prod_i;
      st2_prod_d  <= prod_d;
      st2_err     <= st1_err;
      st2_settled <= st1_settled;
      st2_timed   <= st1_timed;
    end
  end

  // stage 3: sum, floor divide by 256, clamp
  logic signed [42:0] acc, acc_shr, lim_pos, lim_neg;
  logic signed [15:0] drive_next;

  always_comb begin
    acc     = 43'(st2_prod_p) + 43'(st2_prod_i) + 43'(st2_prod_d);
    acc_shr = acc >>> 8;
    lim_pos = $signed({28'd0, output_limit});
    lim_neg = -lim_pos;
    if (acc_shr > lim_pos) begin
      drive_next = lim_pos[15:0];
    end else if (acc_shr < lim_neg) begin
      drive_next = lim_neg[15:0];
    end else begin
      drive_next = acc_shr[15:0];
    end
  end

  logic signed [15:0] out_drive, out_err;
  logic               out_settled, out_timed;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= st2_valid;
    end
    if (out_free && st2_valid) begin
      out_drive   <= drive_next;
      out_err     <= st2_err;
      out_settled <= st2_settled;
      out_timed   <= st2_timed;
    end
  end

  assign result.valid     = out_valid;
  assign result.drive     = out_drive;
  assign result.error_now = out_err;
  assign result.settled   = out_settled;
  assign result.timed_out = out_timed;

endmodule

[hdl/dpp_checker.sv]
module dpp_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input logic signed [15:0]  drive,
  input logic                settled,
  input logic                timed_out
);

  // a timeout always reports settled
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!timed_out || settled))
    else $error("timed_out without settled");

  // limit is at most 32767, so the most negative code never appears
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (drive != 16'sh8000))
    else $error("drive beyond clamp range");

  // pipeline empties on reset
  assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(drive)))
    else $error("stalled result changed");

endmodule

bind drive_position_pid dpp_checker u_dpp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .drive        (result.drive),
  .settled      (result.settled),
  .timed_out    (result.timed_out)
);

[tb/tb_drive_position_pid.sv]
`timescale 1ns / 1ps

module tb_drive_position_pid;
  import dpp_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int PIPE_LAT    = 3;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 100;
  localparam longint SUM_HI  = 64'sd8388607;
  localparam longint SUM_LO  = -64'sd8388608;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] error_now;
    logic                     settled;
    logic                     timed_out;
  } pid_result_t;

  typedef struct {
    logic [DATA_W-1:0]        kp;
    logic [DATA_W-1:0]        ki;
    logic [DATA_W-1:0]        kd;
    logic signed [DATA_W-1:0] target;
    logic [LIMIT_W-1:0]       zone;
    logic [LIMIT_W-1:0]       limit;
    logic [LIMIT_W-1:0]       band;
    logic [BAND_W-1:0]        settle_ticks;
  } pid_settings_t;

  class pid_scoreboard;
    logic [DATA_W-1:0]        kp, ki, kd;
    logic signed [DATA_W-1:0] target;
    logic [LIMIT_W-1:0]       zone, limit, band;
    logic [BAND_W-1:0]        settle_ticks;

    logic signed [DATA_W-1:0] prev_err;
    logic signed [SUM_W-1:0]  integ;
    logic [BAND_W-1:0]        in_band_run;
    logic [TICK_W-1:0]        tick_total;

    pid_result_t pending_results[$];
    int errors;
    int results_seen;

    function new();
      kp = '0; ki = '0; kd = '0; target = '0;
      zone = ZONE_RESET; limit = LIMIT_RESET; band = BAND_RESET;
      settle_ticks = '0;
      prev_err = '0; integ = '0; in_band_run = '0; tick_total = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_GAIN_P:       kp = data;
        REG_GAIN_I:       ki = data;
        REG_GAIN_D:       kd = data;
        REG_TARGET:       target = data;
        REG_INTEG_ZONE:   zone = data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT: limit = data[LIMIT_W-1:0];
        REG_SETTLE_BAND:  band = data[LIMIT_W-1:0];
        REG_SETTLE_TICKS: settle_ticks = data[BAND_W-1:0];
        default: ;
      endcase
    endfunction

    // one control tick: update loop state and queue the result it produces
    function void note_tick(logic start, logic signed [DATA_W-1:0] pos);
      longint err, deriv, mag, acc, lim;
      pid_result_t r;
      if (start) begin
        integ = '0;
        in_band_run = '0;
        tick_total = '0;
      end
      err = clip(longint'(target) - longint'(pos), -32768, 32767);
      deriv = err - longint'(prev_err);
      mag = (err < 0) ? -err : err;
      if (mag < longint'(zone))
        integ = clip(longint'(integ) + err, SUM_LO, SUM_HI);
      else
        integ = '0;
      acc = err * longint'(kp) + longint'(integ) * longint'(ki) + deriv * longint'(kd);
      acc = acc >>> 8;  // floor division by 256
      lim = longint'(limit);
      r.drive = clip(acc, -lim, lim);
      r.error_now = err;
      prev_err = err;
      if (tick_total != '1)
        tick_total++;
      if (mag < longint'(band)) begin
        if (in_band_run != '1)
          in_band_run++;
      end else begin
        in_band_run = '0;
      end
      r.timed_out = (tick_total >= TIMEOUT_TICKS);
      r.settled = (in_band_run > settle_ticks) || r.timed_out;
      pending_results.push_back(r);
    endfunction

    function bit field_ok(string name, logic signed [DATA_W-1:0] want,
                          logic signed [DATA_W-1:0] got);
      if (got !== want) begin
        if (errors < MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(logic signed [DATA_W-1:0] drive,
                               logic signed [DATA_W-1:0] error_now,
                               logic settled, logic timed_out);
      pid_result_t want;
      bit ok;
      results_seen++;
      if (pending_results.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual drive %0d error %0d",
                   $time, drive, error_now);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      ok = field_ok("drive", want.drive, drive);
      ok = field_ok("error_now", want.error_now, error_now) && ok;
      ok = field_ok("settled", want.settled, settled) && ok;
      ok = field_ok("timed_out", want.timed_out, timed_out) && ok;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  dpp_tick_if   tick_ch();
  dpp_result_if res_ch();

  drive_position_pid uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (res_ch)
  );

  pid_scoreboard sb = new();
  pid_settings_t cur;
  bit sender_idles = 1'b0;
  bit sink_idles = 1'b0;
  int hold_off = 0;
  int idle_run = 0;
  int ticks_taken = 0;
  int n_settings = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // transfer monitor: feeds the predictor and checks results
  always @(posedge clk) begin
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready) begin
        sb.note_tick(tick_ch.start_req, tick_ch.position);
        ticks_taken++;
      end
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.drive, res_ch.error_now, res_ch.settled, res_ch.timed_out);
      if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_run = 0;
      else
        idle_run++;
    end
  end

  initial begin
    wait (idle_run >= STALL_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
        res_ch.ready <= 1'b1;
      end else if (sink_idles && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic put_reg(cfg_reg_t idx, logic [DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(pid_settings_t s);
    put_reg(REG_GAIN_P, s.kp);
    put_reg(REG_GAIN_I, s.ki);
    put_reg(REG_GAIN_D, s.kd);
    put_reg(REG_TARGET, s.target);
    put_reg(REG_INTEG_ZONE, DATA_W'(s.zone));
    put_reg(REG_OUTPUT_LIMIT, DATA_W'(s.limit));
    put_reg(REG_SETTLE_BAND, DATA_W'(s.band));
    put_reg(REG_SETTLE_TICKS, DATA_W'(s.settle_ticks));
    cfg_we <= 1'b0;
    cur = s;
    n_settings++;
  endtask

  task automatic send_tick(bit start, logic [DATA_W-1:0] pos);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.start_req <= start;
    tick_ch.position <= pos;
    do @(posedge clk); while (!(tick_ch.valid && tick_ch.ready));
  endtask

  // idle the tick side until every result is back
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_field(int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DATA_W'(hi);
      2, 3:    return DATA_W'($urandom_range(0, hi >> 6));
      default: return DATA_W'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic pid_settings_t random_settings();
    pid_settings_t s;
    s.kp = pick_field(65535);
    s.ki = pick_field(65535);
    s.kd = pick_field(65535);
    s.target = pick_field(65535);
    s.zone = LIMIT_W'(pick_field(32767));
    s.limit = LIMIT_W'(pick_field(32767));
    s.band = LIMIT_W'(pick_field(32767));
    s.settle_ticks = BAND_W'(pick_field(255));
    return s;
  endfunction

  // motions toward the target with noise; a share of the ticks are random positions
  task automatic run_motion(int n_items, int noise_pct);
    int pos, goal, div, amp, left;
    bit start;
    pos = 0;
    div = 1;
    amp = 0;
    left = 0;
    goal = int'(cur.target);
    for (int i = 0; i < n_items; i++) begin
      start = 1'b0;
      if (left == 0) begin
        left = $urandom_range(20, 60);
        pos = int'($urandom_range(0, 65535)) - 32768;
        div = $urandom_range(1, 8);
        amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 64);
        start = 1'b1;
      end
      left--;
      if ($urandom_range(0, 99) < 2)
        start = 1'b1;
      if ($urandom_range(0, 99) < noise_pct) begin
        send_tick(start, DATA_W'($urandom));
      end else begin
        pos = pos + (goal - pos) / div + int'($urandom_range(0, 2 * amp)) - amp;
        pos = (pos > 32767) ? 32767 : ((pos < -32768) ? -32768 : pos);
        send_tick(start, DATA_W'(pos));
      end
    end
  endtask

  initial begin
    pid_settings_t s;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_GAIN_P;
    cfg_data = '0;
    tick_ch.valid = 1'b0;
    tick_ch.start_req = 1'b0;
    tick_ch.position = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: settle run, saturated errors, zone and band boundaries
    s = '{kp: 16'h0180, ki: 16'h0020, kd: 16'h0100, target: 16'sh0500,
          zone: 15'd2560, limit: 15'd3072, band: 15'd256, settle_ticks: 8'd2};
    apply_settings(s);
    repeat (4) send_tick(1'b0, 16'h0500);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b0, 16'h7FFF);
    send_tick(1'b1, 16'h0400);
    send_tick(1'b0, 16'h0401);
    send_tick(1'b0, 16'h0500 - 16'd2560);
    send_tick(1'b0, 16'h0500 - 16'd2559);
    send_tick(1'b0, 16'h0500 - 16'd2559);
    drain();

    s = '{kp: 16'hFFFF, ki: 16'hFFFF, kd: 16'hFFFF, target: 16'sh7FFF,
          zone: 15'h7FFF, limit: 15'h7FFF, band: 15'd0, settle_ticks: 8'hFF};
    apply_settings(s);
    send_tick(1'b1, 16'h8000);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b0, 16'h7FFF);
    send_tick(1'b0, 16'h0000);
    drain();

    s = '{kp: 16'hFFFF, ki: 16'h0000, kd: 16'h0000, target: 16'sh8000,
          zone: 15'd0, limit: 15'd0, band: 15'd0, settle_ticks: 8'd0};
    apply_settings(s);
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b0, 16'h0000);
    drain();

    // long motion without restart: integral windup up, a full-scale error
    // clears it, windup down; band count saturates, timeout alone sets settled
    s = '{kp: 16'h0100, ki: 16'hFFFF, kd: 16'h0200, target: 16'sh0000,
          zone: 15'h7FFF, limit: 15'h7FFF, band: 15'h7FFF, settle_ticks: 8'hFF};
    apply_settings(s);
    sender_idles = 1'b1;
    sink_idles = 1'b1;
    send_tick(1'b1, 16'h0000);
    repeat (285) send_tick(1'b0, DATA_W'(-int'($urandom_range(30000, 32766))));
    send_tick(1'b0, 16'h7FFF);
    repeat (285) send_tick(1'b0, DATA_W'($urandom_range(30000, 32766)));
    repeat (90) send_tick(1'b0, DATA_W'(int'($urandom_range(0, 400)) - 200));
    send_tick(1'b1, 16'h0000);
    send_tick(1'b0, 16'h0010);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      apply_settings(random_settings());
      sender_idles = $urandom_range(0, 3) != 0;
      sink_idles = $urandom_range(0, 3) != 0;
      if (ph == 1) begin
        // output held off while ticks keep coming: pipeline fills, input stalls
        sender_idles = 1'b0;
        hold_off = 80;
      end
      run_motion(16, 15);
      drain();
    end

    // closing stretch at full rate on both sides
    sender_idles = 1'b0;
    sink_idles = 1'b0;
    apply_settings(random_settings());
    run_motion(20, 10);
    drain();
    repeat (PIPE_LAT + 5) @(posedge clk);

    $display("Run covered %0d ticks and %0d results over %0d register settings,",
             ticks_taken, sb.results_seen, n_settings);
    $display("including integral and counter saturation, timeout, zero limits and stalls.");
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
